FILE: src/zvas_pkg.sv
// ----------------------------------------------------------------------------
// zvas_pkg
// Shared types, constants and zigzag helpers for the varint array summer.
// ----------------------------------------------------------------------------
package zvas_pkg;

  localparam int unsigned ZVAS_FIFO_DEPTH = 2;
  localparam int unsigned SumW            = 64;
  localparam int unsigned ShiftW          = 7;
  localparam logic [ShiftW-1:0] GroupBits = 7'd7;

  typedef enum logic [1:0] {
    PH_COUNT = 2'd0,
    PH_SIZE  = 2'd1,
    PH_ITEMS = 2'd2,
    PH_DONE  = 2'd3
  } phase_e;

  typedef struct packed {
    logic full;
    logic not_empty;
  } fifo_status_t;

  function automatic logic [SumW-1:0] unzigzag(input logic [SumW-1:0] v);
    return (v >> 1) ^ {SumW{v[0]}};
  endfunction

  function automatic logic [SumW-1:0] zigzag(input logic [SumW-1:0] v);
    return {v[SumW-2:0], 1'b0} ^ {SumW{v[SumW-1]}};
  endfunction

endpackage

FILE: src/zvas_front.sv
// ----------------------------------------------------------------------------
// zvas_front
// Byte-serial varint parser: tracks block count, skips block sizes, sums
// items and hands the final sum to the queue on the message's last byte.
// ----------------------------------------------------------------------------
module zvas_front
  import zvas_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [7:0]      data_byte_i,
  input  logic            end_of_message_i,
  input  fifo_status_t    fifo_status_i,
  output logic            push_o,
  output logic [SumW-1:0] push_sum_o
);

  phase_e              phase_q, phase_d;
  logic [SumW-1:0]     accum_q, accum_d;
  logic [ShiftW-1:0]   shift_q, shift_d;
  logic [SumW-1:0]     items_q, items_d;
  logic [SumW-1:0]     sum_q, sum_d;

  logic                accept;
  logic                active;
  logic                done_v;
  logic                add_en;
  logic [SumW-1:0]     grp;
  logic [SumW-1:0]     accum_new;
  logic [SumW-1:0]     val;
  logic [SumW-1:0]     items_dec;
  logic [SumW-1:0]     sum_new;

  assign in_ready_o = ~fifo_status_i.full;
  assign accept     = in_valid_i & in_ready_o;
  assign active     = (phase_q != PH_DONE);

  // groups at bit 64 and above drop out
  assign grp       = shift_q[ShiftW-1] ? '0 : (SumW'(data_byte_i[6:0]) << shift_q[5:0]);
  assign accum_new = accum_q | grp;
  assign val       = unzigzag(accum_new);
  assign done_v    = active & ~data_byte_i[7];
  assign items_dec = items_q - SumW'(1);

  // completed item, or item left open at message end
  assign add_en  = (phase_q == PH_ITEMS) & (~data_byte_i[7] | end_of_message_i);
  assign sum_new = sum_q + (add_en ? val : '0);

  assign push_o     = accept & end_of_message_i;
  assign push_sum_o = sum_new;

  always_comb begin
    phase_d = phase_q;
    accum_d = accum_q;
    shift_d = shift_q;
    items_d = items_q;
    sum_d   = sum_q;
    if (accept) begin
      if (end_of_message_i) begin
        phase_d = PH_COUNT;
        accum_d = '0;
        shift_d = '0;
        items_d = '0;
        sum_d   = '0;
      end else if (active) begin
        sum_d = sum_new;
        if (done_v) begin
          accum_d = '0;
          shift_d = '0;
          case (phase_q)
            PH_COUNT: begin
              if (val == '0) begin
                phase_d = PH_DONE;
              end else if (val[SumW-1]) begin
                items_d = '0 - val;
                phase_d = PH_SIZE;
              end else begin
                items_d = val;
                phase_d = PH_ITEMS;
              end
            end
            PH_SIZE: begin
              phase_d = PH_ITEMS;
            end
            PH_ITEMS: begin
              items_d = items_dec;
              if (items_dec == '0) begin
                phase_d = PH_COUNT;
              end
            end
            default: begin
              phase_d = phase_q;
            end
          endcase
        end else begin
          accum_d = accum_new;
          if (!shift_q[ShiftW-1]) begin
            shift_d = shift_q + GroupBits;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_COUNT;
      accum_q <= '0;
      shift_q <= '0;
      items_q <= '0;
      sum_q   <= '0;
    end else begin
      phase_q <= phase_d;
      accum_q <= accum_d;
      shift_q <= shift_d;
      items_q <= items_d;
      sum_q   <= sum_d;
    end
  end

endmodule

FILE: src/zvas_fifo.sv
// ----------------------------------------------------------------------------
// zvas_fifo
// Small queue of finished sums between the parser and the encoder.
// ----------------------------------------------------------------------------
module zvas_fifo
  import zvas_pkg::*;
#(
  parameter int unsigned Depth = ZVAS_FIFO_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  logic [SumW-1:0] push_data_i,
  input  logic            pop_i,
  output logic [SumW-1:0] head_o,
  output fifo_status_t    status_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [SumW-1:0] mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign status_o.full      = (cnt_q == FullCnt);
  assign status_o.not_empty = (cnt_q != '0);
  assign do_push = push_i & ~status_o.full;
  assign do_pop  = pop_i & status_o.not_empty;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

FILE: src/zvas_back.sv
// ----------------------------------------------------------------------------
// zvas_back
// Zigzag varint encoder: emits one 7-bit group of the sum per request.
// ----------------------------------------------------------------------------
module zvas_back
  import zvas_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [SumW-1:0] head_i,
  input  fifo_status_t    fifo_status_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            last_byte_o
);

  logic [SumW-1:0] z_q, z_d;
  logic            vld_q, vld_d;
  logic            more;
  logic            out_acc;

  assign more        = |z_q[SumW-1:7];
  assign out_valid_o = vld_q;
  assign out_byte_o  = {more, z_q[6:0]};
  assign last_byte_o = ~more;
  assign out_acc     = vld_q & out_ready_i;
  assign pop_o       = fifo_status_i.not_empty & (~vld_q | (out_acc & ~more));

  always_comb begin
    z_d   = z_q;
    vld_d = vld_q;
    if (pop_o) begin
      z_d   = zigzag(head_i);
      vld_d = 1'b1;
    end else if (out_acc) begin
      if (more) begin
        z_d = z_q >> 7;
      end else begin
        vld_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    z_q <= z_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

endmodule

FILE: src/zigzag_varint_array_summer.sv
// ----------------------------------------------------------------------------
// zigzag_varint_array_summer
// Sums an array of zigzag varint longs per message; emits the encoded sum.
// ----------------------------------------------------------------------------
// Throughput: one payload byte per cycle unless the sum queue is full.
// The final sum is queued, then loaded into the encoder before its first byte.
// Encoder emits one sum byte per cycle (1 to 10 per message) unless stalled,
// fed by a sum queue of FifoDepth entries, so parsing continues while it drains.
// Reset: asynchronous, active low; clears parser state and empties the queue.
module zigzag_varint_array_summer
  import zvas_pkg::*;
#(
  parameter int unsigned FifoDepth = ZVAS_FIFO_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_message_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       last_byte_o
);

  fifo_status_t    fifo_status;
  logic            push;
  logic [SumW-1:0] push_sum;
  logic            pop;
  logic [SumW-1:0] head;

  zvas_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .data_byte_i      (data_byte_i),
    .end_of_message_i (end_of_message_i),
    .fifo_status_i    (fifo_status),
    .push_o           (push),
    .push_sum_o       (push_sum)
  );

  zvas_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_sum),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (fifo_status)
  );

  zvas_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .fifo_status_i (fifo_status),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .last_byte_o   (last_byte_o)
  );

endmodule

FILE: sim/tb_zigzag_varint_array_summer.sv
// ----------------------------------------------------------------------------
// tb_zigzag_varint_array_summer
// Streams payload requests into the varint array summer and checks every
// emitted sum byte, in order, against a cycle-free model of the parser. A
// short table of hand-picked messages comes first, then random messages:
// well-formed arrays, truncated and overlong ones, noise. Both handshakes
// idle and stall at random in rotating phases.
// ----------------------------------------------------------------------------
module tb_zigzag_varint_array_summer;
  timeunit 1ns;
  timeprecision 1ps;

  import zvas_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RandBytes  = 440;
  localparam int unsigned PhaseLen   = 48;
  localparam int unsigned DirRows    = 26;

  typedef struct packed {
    logic [7:0] b;
    logic       eom;
    logic       typed;
    logic [7:0] tv;
  } dir_row_t;

  typedef struct packed {
    logic [7:0] b;
    logic       eom;
  } payload_t;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } sum_byte_t;

  // typed rows carry the single encoded sum byte of their message
  localparam dir_row_t DirTab [0:DirRows-1] = '{
    {8'h00, 1'b1, 1'b1, 8'h00},
    {8'h02, 1'b0, 1'b0, 8'h00},
    {8'h01, 1'b1, 1'b1, 8'h01},
    {8'h01, 1'b0, 1'b0, 8'h00},
    {8'h05, 1'b0, 1'b0, 8'h00},
    {8'h06, 1'b0, 1'b0, 8'h00},
    {8'h00, 1'b0, 1'b0, 8'h00},
    {8'hFF, 1'b1, 1'b1, 8'h06},
    {8'h81, 1'b1, 1'b1, 8'h00},
    {8'h02, 1'b0, 1'b0, 8'h00},
    {8'h85, 1'b1, 1'b1, 8'h05},
    {8'h04, 1'b0, 1'b0, 8'h00},
    {8'h02, 1'b1, 1'b1, 8'h02},
    {8'h02, 1'b0, 1'b0, 8'h00},
    {8'hFF, 1'b0, 1'b0, 8'h00},
    {8'hFF, 1'b0, 1'b0, 8'h00},
    {8'hFF, 1'b0, 1'b0, 8'h00},
    {8'hFF, 1'b0, 1'b0, 8'h00},
    {8'hFF, 1'b0, 1'b0, 8'h00},
    {8'hFF, 1'b0, 1'b0, 8'h00},
    {8'hFF, 1'b0, 1'b0, 8'h00},
    {8'hFF, 1'b0, 1'b0, 8'h00},
    {8'hFF, 1'b0, 1'b0, 8'h00},
    {8'hFF, 1'b0, 1'b0, 8'h00},
    {8'hFF, 1'b0, 1'b0, 8'h00},
    {8'h00, 1'b1, 1'b0, 8'h00}
  };

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] data_byte_i;
  logic       end_of_message_i;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] out_byte_o;
  logic       last_byte_o;

  zigzag_varint_array_summer uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .data_byte_i      (data_byte_i),
    .end_of_message_i (end_of_message_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_byte_o       (out_byte_o),
    .last_byte_o      (last_byte_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  int unsigned cycle_cnt = 0;
  int          mismatches = 0;
  int          idle_mode = 0;

  sum_byte_t   sum_bytes_q[$];
  payload_t    stim_q[$];
  logic [7:0]  msg_q[$];

  // parser model state
  phase_e      m_phase;
  logic [63:0] m_accum;
  logic [6:0]  m_shift;
  logic [63:0] m_left;
  logic [63:0] m_sum;

  function automatic logic [63:0] zz_to_signed(input logic [63:0] v);
    return (v >> 1) ^ {64{v[0]}};
  endfunction

  function automatic logic [63:0] zz_from_signed(input logic [63:0] v);
    return {v[62:0], 1'b0} ^ {64{v[63]}};
  endfunction

  function automatic int send_idle_pct();
    return (idle_mode == 1) ? 73 : (idle_mode == 3) ? 25 : 0;
  endfunction

  function automatic int recv_stall_pct();
    return (idle_mode == 2) ? 73 : (idle_mode == 3) ? 25 : 0;
  endfunction

  task automatic clear_parser();
    m_phase = PH_COUNT;
    m_accum = '0;
    m_shift = '0;
    m_left  = '0;
    m_sum   = '0;
  endtask

  task automatic predict_sum(input logic [7:0] b, input logic eom, input logic typed,
                             input logic [7:0] tv);
    logic [63:0] val;
    logic [63:0] z;
    logic        open;
    sum_byte_t   s;
    open = 1'b0;
    if (m_phase != PH_DONE) begin
      if (m_shift < 7'd64) m_accum |= {57'd0, b[6:0]} << m_shift;
      if (!b[7]) begin
        val = zz_to_signed(m_accum);
        m_accum = '0;
        m_shift = '0;
        case (m_phase)
          PH_COUNT: begin
            if (val == 64'd0) begin
              m_phase = PH_DONE;
            end else if (val[63]) begin
              m_left  = 64'd0 - val;
              m_phase = PH_SIZE;
            end else begin
              m_left  = val;
              m_phase = PH_ITEMS;
            end
          end
          PH_SIZE: m_phase = PH_ITEMS;
          PH_ITEMS: begin
            m_sum  = m_sum + val;
            m_left = m_left - 64'd1;
            if (m_left == 64'd0) m_phase = PH_COUNT;
          end
          default: ;
        endcase
      end else begin
        if (m_shift < 7'd64) m_shift = m_shift + 7'd7;
        if (m_shift > 7'd70) m_shift = 7'd70;
        open = 1'b1;
      end
    end
    if (eom) begin
      if (open && m_phase == PH_ITEMS) m_sum = m_sum + zz_to_signed(m_accum);
      if (typed) begin
        s.b = tv;
        s.last = 1'b1;
        sum_bytes_q.push_back(s);
      end else begin
        z = zz_from_signed(m_sum);
        while (z >= 64'h80) begin
          s.b = {1'b1, z[6:0]};
          s.last = 1'b0;
          sum_bytes_q.push_back(s);
          z = z >> 7;
        end
        s.b = z[7:0];
        s.last = 1'b1;
        sum_bytes_q.push_back(s);
      end
      clear_parser();
    end
  endtask

  task automatic put_varint(input logic [63:0] v, input int pad);
    logic [7:0] bt;
    do begin
      bt = {1'b0, v[6:0]};
      v = v >> 7;
      if (v != 64'd0 || pad > 0) bt[7] = 1'b1;
      msg_q.push_back(bt);
    end while (v != 64'd0);
    for (int k = 0; k < pad; k++) msg_q.push_back((k < pad - 1) ? 8'h80 : 8'h00);
  endtask

  function automatic int rand_pad();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(1, 6) : 0;
  endfunction

  function automatic logic [63:0] rand_item();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: v = v >> $urandom_range(0, 63);
      1: v = 64'($urandom_range(0, 20)) - 64'd10;
      2: begin
        case ($urandom_range(0, 4))
          0: v = 64'd0;
          1: v = 64'd1;
          2: v = '1;
          3: v = 64'h8000_0000_0000_0000;
          default: v = 64'h7FFF_FFFF_FFFF_FFFF;
        endcase
      end
      3: v = 64'd0 - (v >> $urandom_range(0, 63));
      default: ;
    endcase
    return v;
  endfunction

  task automatic put_blocks(input int nblk);
    int n;
    for (int i = 0; i < nblk; i++) begin
      n = $urandom_range(1, 4);
      if ($urandom_range(0, 1)) begin
        put_varint(zz_from_signed(64'd0 - 64'(n)), rand_pad());
        put_varint(64'($urandom_range(0, 300)), rand_pad());
      end else begin
        put_varint(zz_from_signed(64'(n)), rand_pad());
      end
      for (int j = 0; j < n; j++) put_varint(zz_from_signed(rand_item()), rand_pad());
    end
  endtask

  task automatic make_message();
    int kind;
    int cut;
    payload_t p;
    msg_q.delete();
    kind = $urandom_range(0, 99);
    if (kind < 80) begin
      put_blocks($urandom_range(0, 3));
      if ($urandom_range(0, 99) < 85) begin
        msg_q.push_back(8'h00);
        repeat ($urandom_range(0, 3)) msg_q.push_back(8'($urandom));
      end
      if (msg_q.size() == 0) msg_q.push_back(8'($urandom));
      if (kind >= 70) begin
        cut = $urandom_range(1, msg_q.size());
        while (msg_q.size() > cut) void'(msg_q.pop_back());
      end
    end else if (kind < 90) begin
      repeat ($urandom_range(1, 8)) msg_q.push_back(8'($urandom));
    end else if (kind < 95) begin
      // most negative count, message ends inside the block
      repeat (9) msg_q.push_back(8'hFF);
      msg_q.push_back(8'h01);
      put_varint(64'($urandom_range(0, 300)), 0);
      repeat ($urandom_range(1, 3)) put_varint(zz_from_signed(rand_item()), 0);
    end else begin
      // varint running past 64 bits
      put_varint(zz_from_signed(64'd2), 0);
      repeat ($urandom_range(10, 13)) msg_q.push_back(8'($urandom) | 8'h80);
      msg_q.push_back(8'($urandom) & 8'h7F);
      put_varint(zz_from_signed(rand_item()), 0);
      msg_q.push_back(8'h00);
    end
    foreach (msg_q[i]) begin
      p.b = msg_q[i];
      p.eom = (i == msg_q.size() - 1);
      stim_q.push_back(p);
    end
  endtask

  task automatic send_request(input logic [7:0] b, input logic eom, input logic typed,
                              input logic [7:0] tv);
    while ($urandom_range(0, 99) < send_idle_pct()) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    data_byte_i      <= b;
    end_of_message_i <= eom;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_sum(b, eom, typed, tv);
  endtask

  always @(posedge clk_i) begin : sum_checker
    sum_byte_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (sum_bytes_q.size() == 0) begin
        $display("%0t: unexpected sum byte: expected none, actual byte %h last %b",
                 $time, out_byte_o, last_byte_o);
        mismatches++;
      end else begin
        want = sum_bytes_q.pop_front();
        if (out_byte_o !== want.b) begin
          $display("%0t: out_byte: expected %h, actual %h", $time, want.b, out_byte_o);
          mismatches++;
        end
        if (last_byte_o !== want.last) begin
          $display("%0t: last_byte: expected %b, actual %b", $time, want.last, last_byte_o);
          mismatches++;
        end
      end
    end
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct());
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stimulus
    int idx;
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    data_byte_i      = 8'h00;
    end_of_message_i = 1'b0;
    clear_parser();
    while (stim_q.size() < RandBytes) make_message();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    idx = 0;
    for (int r = 0; r < DirRows; r++) begin
      idle_mode = (idx / PhaseLen) % 4;
      send_request(DirTab[r].b, DirTab[r].eom, DirTab[r].typed, DirTab[r].tv);
      idx++;
    end
    foreach (stim_q[i]) begin
      idle_mode = (idx / PhaseLen) % 4;
      send_request(stim_q[i].b, stim_q[i].eom, 1'b0, 8'h00);
      idx++;
    end
    in_valid_i <= 1'b0;
    while (sum_bytes_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
